### sv/htk_pkg.sv
`timescale 1ns / 1ps
// htk_pkg: shared types, codes and default sizes for the hamming top-k router
// no dependencies

package htk_pkg;

  // default sizes, handed to the top level as parameter defaults
  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int TOP_K_DEF       = 6;
  localparam int SIG_BITS_DEF    = 32;

  // fixed field widths
  localparam int SLOT_W    = 10;
  localparam int SIG_FLD_W = 32;
  localparam int TAG_W     = 10;
  localparam int DIST_W    = 6;
  localparam int ENT_CNT_W = 11;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_W-1:0]    slot;
    logic [SIG_FLD_W-1:0] signature;
    logic [TAG_W-1:0]     tag;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [TAG_W-1:0]  match_tag;
    logic [DIST_W-1:0] distance;
    logic              last;
  } out_item_t;

  // control from the sequencer to the ranked list
  typedef struct packed {
    logic clr;
    logic ins;
  } topk_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } htk_state_t;

endpackage

### sv/htk_dist.sv
`timescale 1ns / 1ps
// htk_dist: registered hamming distance between query and one stored signature
// depends on htk_pkg

module htk_dist import htk_pkg::*; #(
  parameter int SIG_W = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              vld_in,
  input  logic [SIG_W-1:0]  sig_a,
  input  logic [SIG_W-1:0]  sig_b,
  input  logic [TAG_W-1:0]  tag_in,
  output logic              vld_out,
  output logic [DIST_W-1:0] dist_out,
  output logic [TAG_W-1:0]  tag_out
);

  logic [31:0]       diff;
  logic [2:0]        nib_cnt [8];
  logic [DIST_W-1:0] sum;
  logic              vld_r;
  logic [DIST_W-1:0] dist_r;
  logic [TAG_W-1:0]  tag_r;

  // per-nibble counts, then a short sum of eight small values
  always_comb begin
    diff = 32'((sig_a ^ sig_b));
    sum  = '0;
    for (int n = 0; n < 8; n++) begin
      nib_cnt[n] = 3'(diff[4*n]) + 3'(diff[4*n+1]) + 3'(diff[4*n+2]) + 3'(diff[4*n+3]);
    end
    for (int n = 0; n < 8; n++) begin
      sum = sum + DIST_W'(nib_cnt[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= sum;
    tag_r  <= tag_in;
  end

  assign vld_out  = vld_r;
  assign dist_out = dist_r;
  assign tag_out  = tag_r;

endmodule

### sv/htk_topk.sv
`timescale 1ns / 1ps
// htk_topk: sorted list of the k nearest candidates with parallel insertion
// depends on htk_pkg

module htk_topk import htk_pkg::*; #(
  parameter int TOP_K = 6,
  parameter int KW    = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  topk_ctl_t         ctl,
  input  logic [DIST_W-1:0] ins_dist,
  input  logic [TAG_W-1:0]  ins_tag,
  input  logic [KW-1:0]     rd_rank,
  output logic              rd_found,
  output logic [DIST_W-1:0] rd_dist,
  output logic [TAG_W-1:0]  rd_tag
);

  logic [TOP_K-1:0]  vld_r;
  logic [TOP_K-1:0]  vld_nxt;
  logic [DIST_W-1:0] dist_r   [TOP_K];
  logic [DIST_W-1:0] dist_nxt [TOP_K];
  logic [TAG_W-1:0]  tag_r    [TOP_K];
  logic [TAG_W-1:0]  tag_nxt  [TOP_K];
  logic [TOP_K-1:0]  farther;

  // a place is farther if empty or strictly larger; list stays sorted so
  // farther is a run of zeros followed by ones
  always_comb begin
    for (int p = 0; p < TOP_K; p++) begin
      farther[p] = !vld_r[p] || (dist_r[p] > ins_dist);
    end
    for (int p = 0; p < TOP_K; p++) begin
      vld_nxt[p]  = vld_r[p];
      dist_nxt[p] = dist_r[p];
      tag_nxt[p]  = tag_r[p];
      if (ctl.ins && farther[p]) begin
        if (p == 0 || !farther[(p > 0) ? p - 1 : 0]) begin
          vld_nxt[p]  = 1'b1;
          dist_nxt[p] = ins_dist;
          tag_nxt[p]  = ins_tag;
        end else begin
          vld_nxt[p]  = vld_r[(p > 0) ? p - 1 : 0];
          dist_nxt[p] = dist_r[(p > 0) ? p - 1 : 0];
          tag_nxt[p]  = tag_r[(p > 0) ? p - 1 : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < TOP_K; p++) begin
      dist_r[p] <= dist_nxt[p];
      tag_r[p]  <= tag_nxt[p];
    end
  end

  // empty rank reads as zero
  assign rd_found = vld_r[rd_rank];
  assign rd_dist  = vld_r[rd_rank] ? dist_r[rd_rank] : '0;
  assign rd_tag   = vld_r[rd_rank] ? tag_r[rd_rank] : '0;

  // filled places always form a prefix of the list
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_r & (vld_r + 1'b1)) == '0))
    else $error("htk_topk: valid places not contiguous");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clr |=> (vld_r == '0))
    else $error("htk_topk: list not empty after clear");

  a_no_clr_ins: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.clr && ctl.ins))
    else $error("htk_topk: clear and insert together");

endmodule

### sv/hamming_topk_router.sv
`timescale 1ns / 1ps
// hamming_topk_router: table of signatures with top-k hamming nearest search
// depends on htk_pkg, htk_dist, htk_topk
// write item: no result; next item accepted the following cycle
// query item: scan of n stored entries and drain of the pipe, then top_k results
//   one per cycle as the output side takes them (n = entry_count capped at depth)
// the next item is taken once the last rank is loaded and the sequencer is idle again
// scan rate is set by the single table read port and one distance unit:
//   one stored entry per cycle
// rst_n is synchronous: sequencer, list valid bits, output valid and
//   entry_count clear; table contents are undefined until written

module hamming_topk_router import htk_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int TOP_K       = TOP_K_DEF,
  parameter int SIG_BITS    = SIG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_item,
  // entry_count register write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [ENT_CNT_W-1:0] cfg_data
);

  // signature bits actually compared, limited by the 32-bit field
  localparam int SIG_W = (SIG_BITS < SIG_FLD_W) ? SIG_BITS : SIG_FLD_W;
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int KW    = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int MW    = TAG_W + SIG_W;

  htk_state_t st_r, st_nxt;

  logic [ENT_CNT_W-1:0] ent_cnt_r;
  logic [CW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        addr_r, addr_nxt;
  logic [KW-1:0]        rank_r, rank_nxt;
  logic [SIG_W-1:0]     qry_r, qry_nxt;
  logic                 in_xfer;
  logic                 issue;
  logic                 out_load;
  logic                 rd_vld_r;
  logic [MW-1:0]        rd_data_r;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [CW-1:0]        n_sat;
  topk_ctl_t            tk_ctl;
  logic                 dv;
  logic [DIST_W-1:0]    dd;
  logic [TAG_W-1:0]     dt;
  logic                 rk_found;
  logic [DIST_W-1:0]    rk_dist;
  logic [TAG_W-1:0]     rk_tag;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r;

  logic [MW-1:0] table_mem [MAX_ENTRIES];

  assign in_stall  = (st_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = (st_r == ST_IDLE);

  // writes beyond the table depth are dropped
  assign wr_en   = in_xfer && (in_item.kind == KIND_WRITE)
                   && ({22'b0, in_item.slot} < 32'(MAX_ENTRIES));
  assign wr_addr = AW'({22'b0, in_item.slot});

  // entry_count saturates at the table depth
  assign n_sat = ({21'b0, ent_cnt_r} > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                                                          : CW'(ent_cnt_r);

  // sequencer: idle -> scan table -> drain pipe -> emit ranks
  always_comb begin
    st_nxt     = st_r;
    n_nxt      = n_r;
    addr_nxt   = addr_r;
    rank_nxt   = rank_r;
    qry_nxt    = qry_r;
    issue      = 1'b0;
    out_load   = 1'b0;
    tk_ctl.clr = 1'b0;
    tk_ctl.ins = dv;
    unique case (st_r)
      ST_IDLE: begin
        if (in_xfer && (in_item.kind == KIND_QUERY)) begin
          st_nxt     = ST_SCAN;
          n_nxt      = n_sat;
          addr_nxt   = '0;
          rank_nxt   = '0;
          qry_nxt    = in_item.signature[SIG_W-1:0];
          tk_ctl.clr = 1'b1;
          tk_ctl.ins = 1'b0;
        end
      end
      ST_SCAN: begin
        if (addr_r == n_r) begin
          st_nxt = ST_DRAIN;
        end else begin
          issue    = 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last insert lands on the edge where the pipe goes empty
        if (!rd_vld_r && !dv) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          if (rank_r == KW'(TOP_K - 1)) begin
            st_nxt = ST_IDLE;
          end else begin
            rank_nxt = rank_r + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      ent_cnt_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      rd_vld_r <= issue;
      if (cfg_valid && cfg_ready) begin
        ent_cnt_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    addr_r <= addr_nxt;
    rank_r <= rank_nxt;
    qry_r  <= qry_nxt;
  end

  // signature and tag table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= {in_item.tag, in_item.signature[SIG_W-1:0]};
    end
    rd_data_r <= table_mem[addr_r[AW-1:0]];
  end

  htk_dist #(
    .SIG_W (SIG_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_in   (rd_vld_r),
    .sig_a    (rd_data_r[SIG_W-1:0]),
    .sig_b    (qry_r),
    .tag_in   (rd_data_r[MW-1:SIG_W]),
    .vld_out  (dv),
    .dist_out (dd),
    .tag_out  (dt)
  );

  htk_topk #(
    .TOP_K (TOP_K),
    .KW    (KW)
  ) u_topk (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tk_ctl),
    .ins_dist (dd),
    .ins_tag  (dt),
    .rd_rank  (rank_r),
    .rd_found (rk_found),
    .rd_dist  (rk_dist),
    .rd_tag   (rk_tag)
  );

  // output register: holds a result while the far side stalls
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r.found     <= rk_found;
      out_item_r.match_tag <= rk_tag;
      out_item_r.distance  <= rk_dist;
      out_item_r.last      <= (rank_r == KW'(TOP_K - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // scan address never runs past the entry count
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> (addr_r <= n_r))
    else $error("hamming_topk_router: scan address past entry count");

  // ranks are emitted only once the read and distance stages are empty
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT) |-> (!rd_vld_r && !dv))
    else $error("hamming_topk_router: emit with candidates in flight");

  // loading the final rank returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (rank_r == KW'(TOP_K - 1))) |=> (st_r == ST_IDLE))
    else $error("hamming_topk_router: no return to idle after last rank");

  // no table reads are issued outside the scan
  a_issue_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ($past(st_r) == ST_SCAN))
    else $error("hamming_topk_router: table read outside scan");

endmodule
